// ===== src/bn_pkg.sv =====
// ----------------------------------------------------------------------------
// bn_pkg
// Shared constants, reset values and sideband type of the batch-norm pipeline.
// ----------------------------------------------------------------------------
package bn_pkg;

	localparam int CHANNELS_DEF = 64;

	localparam int XW    = 16;  // Q4.12 activation and parameter width
	localparam int VW    = 32;  // Q8.24 variance width
	localparam int PW    = 3 * XW + VW;  // one table row
	localparam int RTW   = 25;  // square root width
	localparam int QW    = 17;  // quotient bits kept before saturation

	localparam logic [XW-1:0] SCALE_RST = 16'd4096;
	localparam logic [XW-1:0] SHIFT_RST = 16'd0;
	localparam logic [XW-1:0] MEAN_RST  = 16'd0;
	localparam logic [VW-1:0] VAR_RST   = 32'd16777216;
	localparam logic [6:0]    ACT_RST   = 7'd64;
	localparam logic [31:0]   EPS_RST   = 32'd168;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic CFG_ACTIVE  = 1'b0;
	localparam logic CFG_EPSILON = 1'b1;

	typedef struct packed {
		logic          err;
		logic          neg;
		logic          zero;
		logic [31:0]   mag;
		logic [XW-1:0] shift;
	} bn_side_t;

endpackage

// ===== src/bn_ram.sv =====
// ----------------------------------------------------------------------------
// bn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bn_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bn_sqrt.sv =====
// ----------------------------------------------------------------------------
// bn_sqrt
// Pipelined integer square root of rad * 2^16, one result bit per stage.
// ----------------------------------------------------------------------------
module bn_sqrt
	import bn_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [32:0]    in_rad,
	input  bn_side_t       in_side,
	output logic           out_valid,
	output logic [RTW-1:0] out_root,
	output bn_side_t       out_side
);

	localparam int STEPS = RTW;
	localparam int RADW  = 2 * STEPS;
	localparam int REMW  = RTW + 3;

	logic            vld_s  [STEPS];
	logic [RADW-1:0] rad_s  [STEPS];
	logic [REMW-1:0] rem_s  [STEPS];
	logic [RTW-1:0]  root_s [STEPS];
	bn_side_t        side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic            vld_i;
		logic [RADW-1:0] rad_i;
		logic [REMW-1:0] rem_i;
		logic [RTW-1:0]  root_i;
		bn_side_t        side_i;
		logic [REMW-1:0] rem_n;
		logic [REMW-1:0] trial;

		if (k == 0) begin : g_head
			assign vld_i  = in_valid;
			assign rad_i  = {1'b0, in_rad, 16'b0};
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_body
			assign vld_i  = vld_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// bring down the next two radicand bits
		assign rem_n = {rem_i[REMW-3:0], rad_i[RADW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_i[RADW-3:0], 2'b00};
				side_s[k] <= side_i;
				if (rem_n >= trial) begin
					rem_s[k]  <= rem_n - trial;
					root_s[k] <= {root_i[RTW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_n;
					root_s[k] <= {root_i[RTW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_root  = root_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

// ===== src/bn_div.sv =====
// ----------------------------------------------------------------------------
// bn_div
// Pipelined rounded division (mag * 2^8 + root / 2) / root, one quotient bit
// per stage, with an overflow flag when the quotient needs more than 17 bits.
// ----------------------------------------------------------------------------
module bn_div
	import bn_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [RTW-1:0] in_root,
	input  bn_side_t       in_side,
	output logic           out_valid,
	output logic [QW-1:0]  out_q,
	output logic           out_ovf,
	output bn_side_t       out_side
);

	localparam int NW = 42;

	logic           vld_s1, vld_s2;
	logic [NW-1:0]  num_s1, num_s2;
	logic [RTW-1:0] den_s1, den_s2;
	bn_side_t       side_s1, side_s2;
	logic           ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= {2'b0, in_side.mag, 8'b0} + NW'(in_root >> 1);
			den_s1  <= in_root;
			side_s1 <= in_side;
			num_s2  <= num_s1;
			den_s2  <= den_s1;
			side_s2 <= side_s1;
			ovf_s2  <= num_s1 >= {den_s1, 17'b0};
		end
	end

	logic            vld_s  [QW];
	logic [NW-1:0]   rem_s  [QW];
	logic [QW-1:0]   q_s    [QW];
	logic [RTW-1:0]  den_s  [QW];
	logic            ovf_s  [QW];
	bn_side_t        side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic           vld_i;
		logic [NW-1:0]  rem_i;
		logic [QW-1:0]  q_i;
		logic [RTW-1:0] den_i;
		logic           ovf_i;
		bn_side_t       side_i;
		logic [NW-1:0]  dsh;

		if (k == 0) begin : g_head
			assign vld_i  = vld_s2;
			assign rem_i  = num_s2;
			assign q_i    = '0;
			assign den_i  = den_s2;
			assign ovf_i  = ovf_s2;
			assign side_i = side_s2;
		end else begin : g_body
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign q_i    = q_s[k-1];
			assign den_i  = den_s[k-1];
			assign ovf_i  = ovf_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign dsh = NW'(den_i) << (QW - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_i;
				ovf_s[k]  <= ovf_i;
				side_s[k] <= side_i;
				if (rem_i >= dsh) begin
					rem_s[k] <= rem_i - dsh;
					q_s[k]   <= {q_i[QW-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_i;
					q_s[k]   <= {q_i[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_q     = q_s[QW-1];
	assign out_ovf   = ovf_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== src/batchnorm_inference_top.sv =====
// ----------------------------------------------------------------------------
// batchnorm_inference_top
// Per-channel batch normalization, inference form, signed Q4.12 in and out.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser is the item kind (0 loads one channel's scale,
// shift, mean and variance, 1 is a data sample); s_axis_tdata carries the
// channel and the fields. A load changes the channel tables and produces no
// output; every sample produces exactly one output transaction.
// Output stream: m_axis_tdata is the saturated result, m_axis_tuser flags a
// sample whose channel is not below active_channels or CHANNELS (result then zero).
// Configuration: cfg_we writes active_channels (index 0) or epsilon
// (index 1); write only while the pipeline is empty.
// Throughput is one transaction per cycle while m_axis_tready does not hold the
// output. From input transaction to output valid a sample passes three front
// stages (table read, difference and variance sum, multiply), 25 square root
// stages, 19 divider stages and the output register. A load followed directly
// by a sample on the same channel sees the new parameters.
// Reset clears the pipeline and marks every table row as holding the
// identity transform; no clearing pass is needed.
// While a result waits with m_axis_tready low the whole pipeline holds and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module batchnorm_inference_top
	import bn_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// channel[5:0], sample[21:6], scale_in[37:22], shift_in[53:38],
	// mean_in[69:54], variance_in[101:70], zero fill [103:102]
	input  logic [103:0] s_axis_tdata,
	// kind[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result[15:0]
	output logic [15:0]  m_axis_tdata,
	// channel_error[0]
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [6:0]  act_q;
	logic [31:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RST;
			eps_q <= EPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE:  act_q <= cfg_data[6:0];
				CFG_EPSILON: eps_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	logic                 en, accept, in_rng, tbl_we;
	logic [5:0]           channel;
	logic signed [XW-1:0] sample;
	logic [AW-1:0]        addr;
	logic [PW-1:0]        rdata;
	logic [CHANNELS-1:0]  row_vld_q;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;
	assign channel       = s_axis_tdata[5:0];
	assign sample        = s_axis_tdata[21:6];
	assign addr          = AW'(channel);
	assign in_rng        = ({1'b0, channel} < act_q) && (32'(channel) < 32'(CHANNELS));
	assign tbl_we        = accept && (s_axis_tuser == KIND_LOAD) && in_rng;

	// row layout: scale, shift, mean, variance from the lowest bit up
	bn_ram #(.W(PW), .DEPTH(CHANNELS)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (addr),
		.wdata (s_axis_tdata[101:22]),
		.re    (en),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (tbl_we) begin
			row_vld_q[addr] <= 1'b1;
		end
	end

	// stage 1: table read
	logic                 vld_s1, err_s1, row_s1;
	logic signed [XW-1:0] x_s1;

	// stage 2: difference and variance sum
	logic                 vld_s2, err_s2;
	logic signed [XW:0]   d_s2;
	logic signed [XW-1:0] scale_s2, shift_s2;
	logic [VW:0]          s_s2;

	// stage 3: product
	logic                 vld_s3, err_s3;
	logic signed [32:0]   p_s3;
	logic [VW:0]          s_s3;
	logic [XW-1:0]        shift_s3;

	logic [XW-1:0] scale_t, shift_t, mean_t;
	logic [VW-1:0] var_t;

	always_comb begin
		if (row_s1) begin
			scale_t = rdata[15:0];
			shift_t = rdata[31:16];
			mean_t  = rdata[47:32];
			var_t   = rdata[79:48];
		end else begin
			scale_t = SCALE_RST;
			shift_t = SHIFT_RST;
			mean_t  = MEAN_RST;
			var_t   = VAR_RST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept && (s_axis_tuser == KIND_SAMPLE);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1   <= !in_rng;
			x_s1     <= sample;
			row_s1   <= row_vld_q[addr];
			err_s2   <= err_s1;
			d_s2     <= {x_s1[XW-1], x_s1} - {mean_t[XW-1], mean_t};
			scale_s2 <= scale_t;
			shift_s2 <= shift_t;
			s_s2     <= {1'b0, var_t} + {1'b0, eps_q};
			err_s3   <= err_s2;
			p_s3     <= d_s2 * scale_s2;
			s_s3     <= s_s2;
			shift_s3 <= shift_s2;
		end
	end

	bn_side_t         side3;
	logic [31:0]      pabs;

	assign pabs        = p_s3[32] ? 32'(-p_s3) : 32'(p_s3);
	assign side3.err   = err_s3;
	assign side3.neg   = p_s3[32];
	assign side3.zero  = (p_s3 == '0);
	assign side3.mag   = pabs;
	assign side3.shift = shift_s3;

	logic           sq_vld;
	logic [RTW-1:0] sq_root;
	bn_side_t       sq_side;

	bn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_rad    (s_s3),
		.in_side   (side3),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	logic          dv_vld, dv_ovf;
	logic [QW-1:0] dv_q;
	bn_side_t      dv_side;

	bn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_vld),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_vld),
		.out_q     (dv_q),
		.out_ovf   (dv_ovf),
		.out_side  (dv_side)
	);

	// sign, add shift, saturate
	logic [QW-1:0]      qv;
	logic signed [QW:0] qs;
	logic signed [QW+1:0] sum;
	logic [XW-1:0]      y;

	always_comb begin
		qv  = dv_ovf ? '0 : dv_q;
		qs  = dv_side.neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
		sum = {qs[QW], qs} + (QW+2)'($signed(dv_side.shift));
		if (dv_side.err) begin
			y = '0;
		end else if (dv_ovf && !dv_side.zero) begin
			y = dv_side.neg ? 16'h8000 : 16'h7fff;
		end else if (sum > 19'sd32767) begin
			y = 16'h7fff;
		end else if (sum < -19'sd32768) begin
			y = 16'h8000;
		end else begin
			y = sum[XW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= y;
			m_axis_tuser <= dv_side.err;
		end
	end

endmodule
